[src/event_counter_table_unit_macros.svh]
// Assertion helpers for the event counter table.
`ifndef EVENT_COUNTER_TABLE_UNIT_MACROS_SVH
`define EVENT_COUNTER_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ECT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ECT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

[src/ect_pkg.sv]
package ect_pkg;

  localparam int CELL_COUNT = 1024;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int DATA_W     = 64;
  localparam int CIU_W      = 11;
  localparam int OP_W       = 2;

  localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(1024);

  localparam logic [OP_W-1:0] OP_NOTIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef logic signed [DATA_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    count_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  function automatic logic is_nonpos(input count_t v);
    return (v == '0) || v[DATA_W-1];
  endfunction

endpackage

[src/ect_ram.sv]
module ect_ram (
  input  logic             clk,
  input  ect_pkg::mem_req_t req,
  output ect_pkg::count_t  rd_data
);

  ect_pkg::count_t mem [ect_pkg::CELL_COUNT];
  ect_pkg::count_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ect_core.sv]
`include "event_counter_table_unit_macros.svh"

module ect_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ect_pkg::CIU_W-1:0]       cells_in_use,
  input  logic                            start,
  output logic                            busy,
  input  logic [ect_pkg::OP_W-1:0]        in_opcode,
  input  logic [ect_pkg::ADDR_W-1:0]      in_cell_index,
  input  ect_pkg::count_t                 in_amount,
  output ect_pkg::mem_req_t               mem_req,
  input  ect_pkg::count_t                 mem_rd_data,
  output logic                            out_valid,
  output logic                            out_status,
  output ect_pkg::count_t                 out_count,
  output logic                            out_ready_res,
  output logic                            out_crossed
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  ect_pkg::addr_t              cnt_r, cnt_nxt;
  logic [ect_pkg::OP_W-1:0]    op_r, op_nxt;
  ect_pkg::addr_t              idx_r, idx_nxt;
  ect_pkg::count_t             amt_r, amt_nxt;
  logic                        ok_r, ok_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_status_r, out_status_nxt;
  ect_pkg::count_t             out_count_r, out_count_nxt;
  logic                        out_ready_r, out_ready_nxt;
  logic                        out_crossed_r, out_crossed_nxt;

  logic [ect_pkg::CIU_W-1:0]   lim;
  logic                        accept;
  ect_pkg::count_t             diff;
  logic                        last_fill;

  assign lim = (cells_in_use < ect_pkg::CIU_W'(ect_pkg::CELL_COUNT)) ?
               cells_in_use : ect_pkg::CIU_W'(ect_pkg::CELL_COUNT);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign diff      = mem_rd_data - amt_r;
  assign last_fill = (ect_pkg::CIU_W'(cnt_r) == lim - ect_pkg::CIU_W'(1));

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    amt_nxt         = amt_r;
    ok_nxt          = ok_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_ready_nxt   = out_ready_r;
    out_crossed_nxt = out_crossed_r;
    mem_req         = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = '0;
        cnt_nxt       = cnt_r + ect_pkg::ADDR_W'(1);
        if (cnt_r == ect_pkg::ADDR_W'(ect_pkg::CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_nxt        = in_opcode;
          idx_nxt       = in_cell_index;
          amt_nxt       = in_amount;
          ok_nxt        = ect_pkg::CIU_W'(in_cell_index) < lim;
          cnt_nxt       = '0;
          mem_req.re    = 1'b1;
          mem_req.raddr = in_cell_index;
          if (in_opcode == ect_pkg::OP_RESET && lim != '0) begin
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_RMW;
          end
        end
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = amt_r;
        cnt_nxt       = cnt_r + ect_pkg::ADDR_W'(1);
        if (last_fill) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        state_nxt       = ST_IDLE;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ect_pkg::STATUS_INVALID;
        out_count_nxt   = '0;
        out_ready_nxt   = 1'b0;
        out_crossed_nxt = 1'b0;
        case (op_r)
          ect_pkg::OP_RESET: begin
            out_status_nxt = ect_pkg::STATUS_OK;
            out_count_nxt  = amt_r;
            out_ready_nxt  = ect_pkg::is_nonpos(amt_r);
          end
          ect_pkg::OP_NOTIFY: begin
            if (ok_r) begin
              mem_req.we      = 1'b1;
              mem_req.waddr   = idx_r;
              mem_req.wdata   = diff;
              out_status_nxt  = ect_pkg::STATUS_OK;
              out_count_nxt   = diff;
              out_ready_nxt   = ect_pkg::is_nonpos(diff);
              out_crossed_nxt = !ect_pkg::is_nonpos(mem_rd_data) &&
                                ect_pkg::is_nonpos(diff);
            end
          end
          ect_pkg::OP_READ: begin
            if (ok_r) begin
              out_status_nxt = ect_pkg::STATUS_OK;
              out_count_nxt  = mem_rd_data;
              out_ready_nxt  = ect_pkg::is_nonpos(mem_rd_data);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r          <= op_nxt;
    idx_r         <= idx_nxt;
    amt_r         <= amt_nxt;
    ok_r          <= ok_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_ready_r   <= out_ready_nxt;
    out_crossed_r <= out_crossed_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_ready_res = out_ready_r;
  assign out_crossed   = out_crossed_r;

  `ECT_ASSERT(a_result_after_rmw, clk, rst_n, out_valid_r |-> $past(state_r == ST_RMW), "result without rmw cycle")
  `ECT_ASSERT(a_accept_locks, clk, rst_n, accept |=> busy, "busy not raised after transfer")
  `ECT_NEVER(a_no_rw_overlap, clk, rst_n, mem_req.we && mem_req.re, "read and write in same cycle")
  `ECT_ASSERT(a_cross_ready, clk, rst_n, out_valid_r && out_crossed_r |-> out_ready_r && (out_status_r == ect_pkg::STATUS_OK), "crossing without ready")

endmodule

[src/event_counter_table_unit.sv]
// Event counter table: 1024 signed 64-bit counters in one synchronous RAM.
// Input: in_opcode/in_cell_index/in_amount are taken at a clock edge with
//   start high and busy low. Opcodes: notify (subtract), read, reset all.
// Result: out_status/out_count/out_ready_res/out_crossed appear for one
//   cycle with out_valid high, registered at the end of the read-modify-write
//   state that follows the transfer (and the fill for reset all); the receiver
//   cannot stall, so each result must be taken when shown.
// Sequencing: notify and read issue the RAM read in the transfer cycle, then
//   pass through the read-modify-write state, with busy high during it. Reset
//   all writes one cell per cycle, then passes through the same state. Busy
//   stays high until the result is shown, so a new command waits for it.
// Configuration: cfg_cells_in_use is written with cfg_valid (cfg_ready is
//   always high); the user must do so only while idle, as the block does not
//   enforce it. Resets to 1024; indices >= min(cells in use, 1024) are invalid.
// Reset: rst_n is synchronous; after it the block sweeps all 1024 cells to
//   zero, one per cycle, holding busy high until the sweep is done.
module event_counter_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ect_pkg::OP_W-1:0]      in_opcode,
  input  logic [ect_pkg::ADDR_W-1:0]    in_cell_index,
  input  ect_pkg::count_t               in_amount,
  output logic                          out_valid,
  output logic                          out_status,
  output ect_pkg::count_t               out_count,
  output logic                          out_ready_res,
  output logic                          out_crossed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ect_pkg::CIU_W-1:0]     cfg_cells_in_use
);

  logic [ect_pkg::CIU_W-1:0] ciu_r, ciu_nxt;
  ect_pkg::mem_req_t         mem_req;
  ect_pkg::count_t           mem_rd_data;

  assign cfg_ready = 1'b1;
  assign ciu_nxt   = (cfg_valid && cfg_ready) ? cfg_cells_in_use : ciu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r <= ect_pkg::CIU_RESET;
    end else begin
      ciu_r <= ciu_nxt;
    end
  end

  ect_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cells_in_use  (ciu_r),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_cell_index (in_cell_index),
    .in_amount     (in_amount),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_ready_res (out_ready_res),
    .out_crossed   (out_crossed)
  );

  ect_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

[test/event_counter_table_unit_tb.sv]
`timescale 1ns / 100ps

module event_counter_table_unit_tb;

  localparam logic [ect_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam ect_pkg::count_t CNT_MIN = {1'b1, {(ect_pkg::DATA_W-1){1'b0}}};
  localparam ect_pkg::count_t CNT_MAX = {1'b0, {(ect_pkg::DATA_W-1){1'b1}}};
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 50;

  typedef struct packed {
    logic            status;
    ect_pkg::count_t count;
    logic            ready;
    logic            crossed;
  } cell_result_t;

  typedef struct {
    logic [ect_pkg::CIU_W-1:0] ciu;
    logic [ect_pkg::OP_W-1:0]  op;
    ect_pkg::addr_t            idx;
    ect_pkg::count_t           amt;
    logic                      typed;
    cell_result_t              want;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [ect_pkg::OP_W-1:0]  in_opcode;
  ect_pkg::addr_t            in_cell_index;
  ect_pkg::count_t           in_amount;
  logic                      out_valid;
  logic                      out_status;
  ect_pkg::count_t           out_count;
  logic                      out_ready_res;
  logic                      out_crossed;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [ect_pkg::CIU_W-1:0] cfg_cells_in_use;

  logic                      cur_typed;
  cell_result_t              cur_want;

  ect_pkg::count_t           cell_shadow [ect_pkg::CELL_COUNT];
  logic [ect_pkg::CIU_W-1:0] ciu_shadow;
  cell_result_t              pending_q [$];
  dir_row_t                  dir_rows [$];

  int mismatches;
  int stall_cycles;
  int n_notify, n_read, n_reset_all, n_unused;
  int n_results, n_invalid, n_crossed, n_cfg;

  event_counter_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_cell_index    (in_cell_index),
    .in_amount        (in_amount),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_ready_res    (out_ready_res),
    .out_crossed      (out_crossed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_cells_in_use (cfg_cells_in_use)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic at_or_below_zero(input ect_pkg::count_t v);
    return v[ect_pkg::DATA_W-1] || (v == '0);
  endfunction

  function automatic int cells_limit(input logic [ect_pkg::CIU_W-1:0] ciu);
    return (int'(ciu) < ect_pkg::CELL_COUNT) ? int'(ciu) : ect_pkg::CELL_COUNT;
  endfunction

  // updates the shadow table and returns the result the block should give
  function automatic cell_result_t apply_cell_op(input logic [ect_pkg::OP_W-1:0] op,
                                                 input ect_pkg::addr_t idx,
                                                 input ect_pkg::count_t amt);
    cell_result_t r;
    int lim;
    ect_pkg::count_t prev;
    ect_pkg::count_t now;
    r = '0;
    r.status = ect_pkg::STATUS_INVALID;
    lim = cells_limit(ciu_shadow);
    if (op == ect_pkg::OP_RESET) begin
      for (int i = 0; i < lim; i++) cell_shadow[i] = amt;
      r.status = ect_pkg::STATUS_OK;
      r.count = amt;
      r.ready = at_or_below_zero(amt);
    end else if (op != OP_UNUSED && int'(idx) < lim) begin
      r.status = ect_pkg::STATUS_OK;
      prev = cell_shadow[idx];
      if (op == ect_pkg::OP_NOTIFY) begin
        now = prev - amt;
        cell_shadow[idx] = now;
        r.crossed = !at_or_below_zero(prev) && at_or_below_zero(now);
      end else begin
        now = prev;
      end
      r.count = now;
      r.ready = at_or_below_zero(now);
    end
    return r;
  endfunction

  function automatic void dir_row(input logic [ect_pkg::CIU_W-1:0] ciu,
                                  input logic [ect_pkg::OP_W-1:0] op,
                                  input ect_pkg::addr_t idx, input ect_pkg::count_t amt,
                                  input logic typed, input logic st,
                                  input ect_pkg::count_t cnt, input logic rdy,
                                  input logic crs);
    dir_row_t row;
    row.ciu = ciu;
    row.op = op;
    row.idx = idx;
    row.amt = amt;
    row.typed = typed;
    row.want.status = st;
    row.want.count = cnt;
    row.want.ready = rdy;
    row.want.crossed = crs;
    dir_rows.push_back(row);
  endfunction

  // transfer tracking, result checking and watchdog
  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        ciu_shadow = cfg_cells_in_use;
        n_cfg++;
        moved = 1'b1;
      end
      if (start && !busy) begin
        got = apply_cell_op(in_opcode, in_cell_index, in_amount);
        pending_q.push_back(cur_typed ? cur_want : got);
        case (in_opcode)
          ect_pkg::OP_NOTIFY: n_notify++;
          ect_pkg::OP_READ:   n_read++;
          ect_pkg::OP_RESET:  n_reset_all++;
          default:            n_unused++;
        endcase
        moved = 1'b1;
      end
      if (out_valid) begin
        moved = 1'b1;
        n_results++;
        if (out_status == ect_pkg::STATUS_INVALID) n_invalid++;
        if (out_crossed) n_crossed++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: status %0d count %0d", $realtime,
                     out_status, out_count);
        end else begin
          want = pending_q.pop_front();
          if (out_status !== want.status || out_count !== want.count ||
              out_ready_res !== want.ready || out_crossed !== want.crossed) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch: want status %0d count %0d ready %0d crossed %0d,",
                        " got %0d %0d %0d %0d"}, $realtime, want.status, want.count,
                       want.ready, want.crossed, out_status, out_count, out_ready_res,
                       out_crossed);
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results pending", $realtime,
                 stall_cycles, pending_q.size());
        $display("event_counter_table_unit test failed");
        $finish;
      end
    end
  end

  task automatic send_cmd(input logic [ect_pkg::OP_W-1:0] op, input ect_pkg::addr_t idx,
                          input ect_pkg::count_t amt, input logic typed,
                          input cell_result_t want);
    start <= 1'b1;
    in_opcode <= op;
    in_cell_index <= idx;
    in_amount <= amt;
    cur_typed <= typed;
    cur_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_q.size() != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cells_in_use(input logic [ect_pkg::CIU_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_cells_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic ect_pkg::count_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return CNT_MIN;
      1:       return CNT_MAX;
      2:       return '0;
      3:       return ect_pkg::count_t'(1);
      default: return -ect_pkg::count_t'(1);
    endcase
  endfunction

  initial begin
    logic [ect_pkg::CIU_W-1:0] phase_ciu [8];
    logic [ect_pkg::CIU_W-1:0] active_ciu;
    logic [ect_pkg::OP_W-1:0] op;
    ect_pkg::addr_t idx;
    ect_pkg::count_t amt;
    int lim;
    int r;

    phase_ciu = '{11'd8, 11'd1024, 11'd3, 11'd2047, 11'd1, 11'd0, 11'd600, 11'd64};
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = ect_pkg::OP_READ;
    in_cell_index = '0;
    in_amount = '0;
    cfg_valid = 1'b0;
    cfg_cells_in_use = ect_pkg::CIU_RESET;
    cur_typed = 1'b0;
    cur_want = '0;
    ciu_shadow = ect_pkg::CIU_RESET;
    for (int i = 0; i < ect_pkg::CELL_COUNT; i++) cell_shadow[i] = '0;
    mismatches = 0;
    stall_cycles = 0;
    n_notify = 0; n_read = 0; n_reset_all = 0; n_unused = 0;
    n_results = 0; n_invalid = 0; n_crossed = 0; n_cfg = 0;

    dir_row(1024, ect_pkg::OP_READ,      0, 0,        1, ect_pkg::STATUS_OK, 0,       1, 0);
    dir_row(1024, ect_pkg::OP_READ,   1023, 0,        1, ect_pkg::STATUS_OK, 0,       1, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY,    5, -64'sd10, 1, ect_pkg::STATUS_OK, 64'sd10, 0, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY,    5, 64'sd10,  1, ect_pkg::STATUS_OK, 0,       1, 1);
    dir_row(1024, ect_pkg::OP_NOTIFY, 1023, CNT_MIN,  1, ect_pkg::STATUS_OK, CNT_MIN, 1, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY, 1023, 64'sd1,   0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY, 1023, CNT_MAX,  0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1024, OP_UNUSED, 1023, CNT_MAX, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);
    dir_row(1024, ect_pkg::OP_RESET,  1023, CNT_MAX,  1, ect_pkg::STATUS_OK, CNT_MAX, 0, 0);
    dir_row(1024, ect_pkg::OP_READ,    512, 0,        0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY,  512, -64'sd1,  0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1024, ect_pkg::OP_RESET,     0, CNT_MIN,  1, ect_pkg::STATUS_OK, CNT_MIN, 1, 0);
    dir_row(1024, ect_pkg::OP_RESET,     0, 0,        1, ect_pkg::STATUS_OK, 0,       1, 0);
    dir_row(1024, ect_pkg::OP_NOTIFY, 1023, -64'sd1,  0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(4, ect_pkg::OP_NOTIFY, 4, 64'sd5, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);
    dir_row(4, ect_pkg::OP_READ, 1023, 0, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);
    dir_row(4,    ect_pkg::OP_RESET,  1023, 64'sd7,   1, ect_pkg::STATUS_OK, 64'sd7,  0, 0);
    dir_row(4,    ect_pkg::OP_READ,      3, 0,        0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(4,    ect_pkg::OP_NOTIFY,    3, 64'sd7,   0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(0, ect_pkg::OP_READ, 0, 0, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);
    dir_row(0,    ect_pkg::OP_RESET,     0, 64'sd5,   1, ect_pkg::STATUS_OK, 64'sd5,  0, 0);
    dir_row(0, ect_pkg::OP_NOTIFY, 0, 64'sd1, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);
    dir_row(2047, ect_pkg::OP_READ,   1023, 0,        0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(2047, ect_pkg::OP_READ,      4, 0,        0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1,    ect_pkg::OP_READ,      0, 0,        0, ect_pkg::STATUS_OK, 0,       0, 0);
    dir_row(1, ect_pkg::OP_READ, 1, 0, 1, ect_pkg::STATUS_INVALID, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; rows carrying a register value switch it when idle
    active_ciu = ect_pkg::CIU_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].ciu != active_ciu) begin
        write_cells_in_use(dir_rows[i].ciu);
        active_ciu = dir_rows[i].ciu;
      end
      send_cmd(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].amt, dir_rows[i].typed,
               dir_rows[i].want);
      sender_gap();
    end

    // random phases, one register setting each; the last one runs back to back
    foreach (phase_ciu[p]) begin
      write_cells_in_use(phase_ciu[p]);
      lim = cells_limit(phase_ciu[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) op = ect_pkg::OP_NOTIFY;
        else if (r < 85) op = ect_pkg::OP_READ;
        else if (r < 95) op = ect_pkg::OP_RESET;
        else op = OP_UNUSED;

        r = $urandom_range(0, 99);
        if (r < 60)
          idx = (lim == 0) ? ect_pkg::addr_t'($urandom_range(0, 3))
                           : ect_pkg::addr_t'($urandom_range(0, ((lim < 6) ? lim : 6) - 1));
        else if (r < 75)
          idx = (lim == 0) ? ect_pkg::addr_t'(0)
                           : ect_pkg::addr_t'(lim - 1 + $urandom_range(0, 1));
        else
          idx = ect_pkg::addr_t'($urandom_range(0, ect_pkg::CELL_COUNT - 1));

        r = $urandom_range(0, 99);
        if (op == ect_pkg::OP_RESET && r < 60)
          amt = ect_pkg::count_t'($urandom_range(1, 12));
        else if (r < 50)
          amt = ect_pkg::count_t'($urandom_range(0, 6)) - ect_pkg::count_t'(1);
        else if (r < 65)
          amt = pick_extreme();
        else
          amt = {$urandom, $urandom};

        send_cmd(op, idx, amt, 1'b0, '0);
        if (p != $size(phase_ciu) - 1) sender_gap();
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d notify, %0d read, %0d reset-all, %0d unused-opcode commands",
             n_notify, n_read, n_reset_all, n_unused);
    $display("%0d results (%0d invalid, %0d zero crossings), %0d register writes, %0d bad",
             n_results, n_invalid, n_crossed, n_cfg, mismatches);
    if (mismatches == 0) begin
      $display("event_counter_table_unit test passed");
    end else begin
      $display("event_counter_table_unit test failed");
    end
    $finish;
  end

endmodule
